@@ design/chained_hash_table_macros.svh @@
// ----------------------------------------------------------------------------
// chained hash table assertion macros
// implication checks used by the top level, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_MACROS_SVH
`define CHAINED_HASH_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CHT_ASSERT_IMPL(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("chained_hash_table: same-cycle check failed");

// next-cycle implication
`define CHT_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("chained_hash_table: next-cycle check failed");

`else

`define CHT_ASSERT_IMPL(label, ck, rn, ante, cons)
`define CHT_ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

@@ design/chtbl_pkg.sv @@
// ----------------------------------------------------------------------------
// chtbl_pkg
// sizes, codes and request/result types shared by the hash table modules
// ----------------------------------------------------------------------------
package chtbl_pkg;

  // table geometry
  localparam int BUCKETS    = 10;
  localparam int CAPACITY   = 64;
  localparam int NAME_BYTES = 50;

  // fixed field widths
  localparam int KEY_W     = 31;
  localparam int WORD_W    = 64;
  localparam int LAST_W    = 16;
  localparam int NAME_BITS = 6 * WORD_W + LAST_W;
  localparam int COUNT_W   = 7;

  // derived widths
  localparam int BKT_W = $clog2(BUCKETS);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // bucket hash by reciprocal multiplication: key / BUCKETS equals
  // (key * RECIP) >> HASH_SH for every KEY_W-bit key
  localparam int HASH_SH = KEY_W + BKT_W;
  localparam int RECIP_W = 32;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << HASH_SH) + 64'(BUCKETS - 1)) / 64'(BUCKETS));

  // name bytes past NAME_BYTES are dropped
  localparam int NAME_KEEP = (NAME_BYTES * 8 < NAME_BITS) ? NAME_BYTES * 8 : NAME_BITS;
  localparam logic [NAME_BITS-1:0] NAME_MASK =
    {NAME_BITS{1'b1}} >> (NAME_BITS - NAME_KEEP);

  // request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISS     = 2'd3
  } status_t;

  typedef struct packed {
    op_t                  op;
    logic [KEY_W-1:0]     key;
    logic [BKT_W-1:0]     bkt;
    logic [NAME_BITS-1:0] name;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   count;
    logic [NAME_BITS-1:0] name;
  } res_t;

endpackage

@@ design/chained_hash_table.sv @@
// ----------------------------------------------------------------------------
// chained_hash_table
// hash table with separate chaining over a fixed entry store
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake            payload
//   -------  ---  -------------------  ------------------------------------
//   in_      in   in_valid/in_stall    operation, key, name_w0..name_w6
//   out_     out  out_valid/out_stall  status, bucket_count, found_w0..found_w6
//
// the front registers a request, then works out the bucket by reciprocal
//   multiplication and pushes into the 2-deep queue; it takes no new
//   request until that push is done
// the back finishes an insert, a refused insert or a search of an empty
//   bucket as it pops the request; a search reads one chain entry a cycle,
//   up to CAPACITY of them, and holds the last one until the result slot
//   frees up; each result is registered in the output register
// reset is synchronous and active low; it empties the bucket table and the
//   entry count at once, no clearing pass
// a stalled result waits in the output register and holds the back; the
//   front keeps taking requests until the queue fills
//
`include "chained_hash_table_macros.svh"

module chained_hash_table (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [chtbl_pkg::KEY_W-1:0]   in_key,
  input  logic [chtbl_pkg::WORD_W-1:0]  in_name_w0,
  input  logic [chtbl_pkg::WORD_W-1:0]  in_name_w1,
  input  logic [chtbl_pkg::WORD_W-1:0]  in_name_w2,
  input  logic [chtbl_pkg::WORD_W-1:0]  in_name_w3,
  input  logic [chtbl_pkg::WORD_W-1:0]  in_name_w4,
  input  logic [chtbl_pkg::WORD_W-1:0]  in_name_w5,
  input  logic [chtbl_pkg::LAST_W-1:0]  in_name_w6,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [chtbl_pkg::COUNT_W-1:0] out_bucket_count,
  output logic [chtbl_pkg::WORD_W-1:0]  out_found_w0,
  output logic [chtbl_pkg::WORD_W-1:0]  out_found_w1,
  output logic [chtbl_pkg::WORD_W-1:0]  out_found_w2,
  output logic [chtbl_pkg::WORD_W-1:0]  out_found_w3,
  output logic [chtbl_pkg::WORD_W-1:0]  out_found_w4,
  output logic [chtbl_pkg::WORD_W-1:0]  out_found_w5,
  output logic [chtbl_pkg::LAST_W-1:0]  out_found_w6
);
  import chtbl_pkg::*;

  // front to queue
  logic q_push;
  req_t push_req;
  logic q_full;

  // queue to back
  logic q_valid;
  logic q_pop;
  req_t pop_req;

  // back to output register
  logic res_valid;
  logic res_ready;
  res_t res;

  // output register
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  chtbl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_key       (in_key),
    .in_name_w0   (in_name_w0),
    .in_name_w1   (in_name_w1),
    .in_name_w2   (in_name_w2),
    .in_name_w3   (in_name_w3),
    .in_name_w4   (in_name_w4),
    .in_name_w5   (in_name_w5),
    .in_name_w6   (in_name_w6),
    .q_push       (q_push),
    .q_req        (push_req),
    .q_full       (q_full)
  );

  chtbl_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .pop_req  (pop_req)
  );

  chtbl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_req     (pop_req),
    .q_pop     (q_pop),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // slot is free when empty or being drained this cycle
  assign res_ready = ~out_valid_r | ~out_stall;

  always_comb begin
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_bucket_count = out_res_r.count;
  assign out_found_w0     = out_res_r.name[0*WORD_W +: WORD_W];
  assign out_found_w1     = out_res_r.name[1*WORD_W +: WORD_W];
  assign out_found_w2     = out_res_r.name[2*WORD_W +: WORD_W];
  assign out_found_w3     = out_res_r.name[3*WORD_W +: WORD_W];
  assign out_found_w4     = out_res_r.name[4*WORD_W +: WORD_W];
  assign out_found_w5     = out_res_r.name[5*WORD_W +: WORD_W];
  assign out_found_w6     = out_res_r.name[6*WORD_W +: LAST_W];

  // back never issues a result into an occupied slot
  `CHT_ASSERT_IMPL(a_res_slot, clk, rst_n, res_valid, res_ready)
  // front never pushes into a full queue
  `CHT_ASSERT_IMPL(a_q_push, clk, rst_n, q_push, !q_full)
  // name is only carried by a hit
  `CHT_ASSERT_IMPL(a_name_zero, clk, rst_n, res_valid && (res.status != ST_FOUND), res.name == '0)
  // an issued result shows up on the output next cycle
  `CHT_ASSERT_NEXT(a_out_load, clk, rst_n, res_valid, out_valid)

endmodule

@@ design/chtbl_front.sv @@
// ----------------------------------------------------------------------------
// chtbl_front
// takes requests, reduces the key to its bucket and queues the request
// ----------------------------------------------------------------------------
module chtbl_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [chtbl_pkg::KEY_W-1:0]    in_key,
  input  logic [chtbl_pkg::WORD_W-1:0]   in_name_w0,
  input  logic [chtbl_pkg::WORD_W-1:0]   in_name_w1,
  input  logic [chtbl_pkg::WORD_W-1:0]   in_name_w2,
  input  logic [chtbl_pkg::WORD_W-1:0]   in_name_w3,
  input  logic [chtbl_pkg::WORD_W-1:0]   in_name_w4,
  input  logic [chtbl_pkg::WORD_W-1:0]   in_name_w5,
  input  logic [chtbl_pkg::LAST_W-1:0]   in_name_w6,
  output logic                           q_push,
  output chtbl_pkg::req_t                q_req,
  input  logic                           q_full
);
  import chtbl_pkg::*;

  logic                     busy_r, busy_nxt;
  op_t                      op_r;
  logic [KEY_W-1:0]         key_r;
  logic [NAME_BITS-1:0]     name_r;

  logic                     accept;
  logic [KEY_W+RECIP_W-1:0] prod;
  logic [BKT_W-1:0]         quo_lo;
  logic [2*BKT_W-1:0]       quo_d;
  logic [BKT_W-1:0]         bkt;

  assign in_stall = busy_r;
  assign accept   = in_valid & ~busy_r;
  assign q_push   = busy_r & ~q_full;

  // bucket = key - quotient * BUCKETS; the bucket fits in BKT_W bits,
  // so only the low bits of quotient * BUCKETS are needed
  assign prod   = {{RECIP_W{1'b0}}, key_r} * {{KEY_W{1'b0}}, RECIP};
  assign quo_lo = prod[HASH_SH +: BKT_W];
  assign quo_d  = {{BKT_W{1'b0}}, quo_lo} * (2*BKT_W)'(BUCKETS);
  assign bkt    = key_r[BKT_W-1:0] - quo_d[BKT_W-1:0];

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (q_push) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_operation);
      key_r  <= in_key;
      name_r <= {in_name_w6, in_name_w5, in_name_w4, in_name_w3,
                 in_name_w2, in_name_w1, in_name_w0} & NAME_MASK;
    end
  end

  always_comb begin
    q_req.op   = op_r;
    q_req.key  = key_r;
    q_req.bkt  = bkt;
    q_req.name = name_r;
  end

endmodule

@@ design/chtbl_fifo.sv @@
// ----------------------------------------------------------------------------
// chtbl_fifo
// short request queue between the front and the back
// ----------------------------------------------------------------------------
module chtbl_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  chtbl_pkg::req_t push_req,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output chtbl_pkg::req_t pop_req
);
  import chtbl_pkg::*;

  req_t              slots_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & q_valid;
  assign pop_req = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

@@ design/chtbl_back.sv @@
// ----------------------------------------------------------------------------
// chtbl_back
// bucket table, entry store and chain walker; carries out queued requests
// ----------------------------------------------------------------------------
module chtbl_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  chtbl_pkg::req_t q_req,
  output logic            q_pop,
  input  logic            res_ready,
  output logic            res_valid,
  output chtbl_pkg::res_t res
);
  import chtbl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [IDX_W-1:0]     link;
    logic [NAME_BITS-1:0] name;
  } entry_t;

  // entry store, one row per record
  entry_t           mem [CAPACITY];
  entry_t           rd_q;
  entry_t           wr_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;

  logic [IDX_W-1:0] bucket_head_r [BUCKETS];
  logic [CNT_W-1:0] bucket_size_r [BUCKETS];
  logic             tbl_we;
  logic [IDX_W-1:0] head_nxt;
  logic [CNT_W-1:0] size_nxt;

  state_t           st_r, st_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [IDX_W-1:0] cur_r;
  logic [KEY_W-1:0] key_r;
  logic [BKT_W-1:0] bkt_r;

  logic [CNT_W-1:0] sz;
  logic [IDX_W-1:0] hd;
  logic             full;
  logic             hit;
  logic             walk_end;

  assign sz       = bucket_size_r[q_req.bkt];
  assign hd       = bucket_head_r[q_req.bkt];
  assign full     = (used_r == CNT_W'(CAPACITY));
  assign hit      = (rd_q.key == key_r);
  assign walk_end = hit | (left_r == CNT_W'(1));

  always_comb begin
    st_nxt       = st_r;
    q_pop        = 1'b0;
    res_valid    = 1'b0;
    res.status   = ST_MISS;
    res.count    = '0;
    res.name     = '0;
    wr_en        = 1'b0;
    wr_addr      = used_r[IDX_W-1:0];
    wr_data.key  = q_req.key;
    wr_data.link = hd;
    wr_data.name = q_req.name;
    tbl_we       = 1'b0;
    head_nxt     = used_r[IDX_W-1:0];
    size_nxt     = sz + 1'b1;
    used_nxt     = used_r;
    left_nxt     = left_r;
    rd_addr      = cur_r;
    case (st_r)
      S_IDLE: begin
        if (q_valid && res_ready) begin
          q_pop = 1'b1;
          if (q_req.op == OP_INSERT) begin
            res_valid = 1'b1;
            if (full) begin
              res.status = ST_FULL;
              res.count  = COUNT_W'(sz);
            end else begin
              res.status = ST_INSERTED;
              res.count  = COUNT_W'(size_nxt);
              wr_en      = 1'b1;
              tbl_we     = 1'b1;
              used_nxt   = used_r + 1'b1;
            end
          end else if (sz == '0) begin
            res_valid  = 1'b1;
            res.status = ST_MISS;
            res.count  = COUNT_W'(sz);
          end else begin
            rd_addr  = hd;
            left_nxt = sz;
            st_nxt   = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (walk_end) begin
          // hold the current entry until the result slot frees up
          if (res_ready) begin
            res_valid = 1'b1;
            res.count = COUNT_W'(bucket_size_r[bkt_r]);
            if (hit) begin
              res.status = ST_FOUND;
              res.name   = rd_q.name;
            end else begin
              res.status = ST_MISS;
            end
            st_nxt = S_IDLE;
          end
        end else begin
          rd_addr  = rd_q.link;
          left_nxt = left_r - 1'b1;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      used_r <= '0;
      for (int b = 0; b < BUCKETS; b++) begin
        bucket_head_r[b] <= '0;
        bucket_size_r[b] <= '0;
      end
    end else begin
      st_r   <= st_nxt;
      used_r <= used_nxt;
      if (tbl_we) begin
        bucket_head_r[q_req.bkt] <= head_nxt;
        bucket_size_r[q_req.bkt] <= size_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    cur_r  <= rd_addr;
    if (q_pop) begin
      key_r <= q_req.key;
      bkt_r <= q_req.bkt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

endmodule
